[hw/rtl/sse_pkg.sv]
// Shared types and constants of the set statistics engine.
package sse_pkg;

  localparam int unsigned MaxItemsDef   = 256;
  localparam int unsigned ValueRangeDef = 128;

  localparam int unsigned SampleW = 7;
  localparam int unsigned TotalW  = 15;
  localparam int unsigned CountW  = 9;
  localparam int unsigned MedianW = 8;

  typedef struct packed {
    logic [SampleW-1:0] sample_value;
    logic               end_of_set;
  } sample_t;

  typedef struct packed {
    logic [SampleW-1:0] minimum;
    logic [SampleW-1:0] maximum;
    logic [TotalW-1:0]  total;
    logic [CountW-1:0]  item_count;
    logic [MedianW-1:0] median_doubled;
    logic [SampleW-1:0] most_frequent;
    logic               is_mirror;
    logic               overflowed;
  } result_t;

  // Head of the front queue as seen by the back end.
  typedef struct packed {
    logic    valid;
    sample_t item;
  } queue_head_t;

  // Back end status and requests towards the front end.
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_status_t;

endpackage

[hw/rtl/sse_stream_if.sv]
// Valid/ready stream channel carrying one beat of payload.
interface sse_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/sse_front.sv]
// Front end: accepts sample beats into a short queue for the back end.
module sse_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  sse_pkg::sample_t      in_data_i,
  output logic                  in_ready_o,
  input  sse_pkg::back_status_t status_i,
  output sse_pkg::queue_head_t  head_o
);
  import sse_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  sample_t          slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]    fill_q, fill_d;
  logic             push, pop;

  // Hold off new beats while the queue is full or the back end sweeps the histogram.
  assign in_ready_o = (fill_q != (PtrW+1)'(Depth)) && !status_i.clearing;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = status_i.pop && (fill_q != '0);

  assign head_o.valid = (fill_q != '0);
  assign head_o.item  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

[hw/rtl/sse_back.sv]
// Back end: loads samples, walks the histogram and the store, emits results.
module sse_back #(
  parameter int unsigned MAX_ITEMS   = sse_pkg::MaxItemsDef,
  parameter int unsigned VALUE_RANGE = sse_pkg::ValueRangeDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sse_pkg::queue_head_t  head_i,
  output sse_pkg::back_status_t status_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output sse_pkg::result_t      res_data_o
);
  import sse_pkg::*;

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned VW = (VALUE_RANGE > 1) ? $clog2(VALUE_RANGE) : 1;

  typedef enum logic [2:0] {
    StClear, StPop, StUpdate, StHist, StHistTail, StMirror, StMirrorTail, StEmit
  } state_e;

  state_e          state_q;
  logic [VW-1:0]   store_q [MAX_ITEMS];
  logic [CW-1:0]   hist_q  [VALUE_RANGE];

  logic [VW-1:0]   val_q, walk_q, walk_del_q;
  logic            last_q, hval_q, mval_q;
  logic [CW-1:0]   count_q, seen_q, best_cnt_q, idx_q;
  logic [VW-1:0]   min_q, max_q, med_a_q, med_b_q, mode_q;
  logic [TotalW-1:0] sum_q;
  logic            drop_q, found_a_q, found_b_q, mirror_q;
  logic            ovalid_q;
  result_t         res_q;

  // Memory ports.
  logic            h_we, s_we;
  logic [VW-1:0]   h_wa, h_ra;
  logic [CW-1:0]   h_wd, h_rd_q;
  logic [AW-1:0]   s_wa, s_ra_a, s_ra_b;
  logic [VW-1:0]   s_rd_a_q, s_rd_b_q;

  logic [VW-1:0]   sample_clamped;
  logic [CW-1:0]   pos_a, pos_b, half, seen_next, idx_b;
  logic            room, out_free;

  always_comb begin
    if (32'(head_i.item.sample_value) >= 32'(VALUE_RANGE)) begin
      sample_clamped = VW'(VALUE_RANGE - 1);
    end else begin
      sample_clamped = VW'(head_i.item.sample_value);
    end
  end

  assign room      = (count_q < CW'(MAX_ITEMS));
  assign pos_a     = (count_q - 1'b1) >> 1;
  assign pos_b     = count_q >> 1;
  assign half      = count_q >> 1;
  assign seen_next = seen_q + h_rd_q;
  assign idx_b     = count_q - 1'b1 - idx_q;
  assign out_free  = !ovalid_q || res_ready_i;

  assign status_o.pop      = (state_q == StPop) && head_i.valid;
  assign status_o.clearing = (state_q == StClear);

  always_comb begin
    h_we   = 1'b0;
    h_wa   = walk_q;
    h_wd   = '0;
    h_ra   = walk_q;
    s_we   = 1'b0;
    s_wa   = count_q[AW-1:0];
    s_ra_a = idx_q[AW-1:0];
    s_ra_b = idx_b[AW-1:0];
    unique case (state_q)
      StClear: begin
        h_we = 1'b1;
      end
      StPop: begin
        h_ra = sample_clamped;
        s_we = head_i.valid && room;
      end
      StUpdate: begin
        h_we = 1'b1;
        h_wa = val_q;
        h_wd = h_rd_q + 1'b1;
      end
      StHist: begin
        h_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hist_q[h_wa] <= h_wd;
    end
    h_rd_q <= hist_q[h_ra];
    if (s_we) begin
      store_q[s_wa] <= sample_clamped;
    end
    s_rd_a_q <= store_q[s_ra_a];
    s_rd_b_q <= store_q[s_ra_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      walk_q     <= '0;
      walk_del_q <= '0;
      val_q      <= '0;
      last_q     <= 1'b0;
      hval_q     <= 1'b0;
      mval_q     <= 1'b0;
      count_q    <= '0;
      seen_q     <= '0;
      best_cnt_q <= '0;
      idx_q      <= '0;
      min_q      <= VW'(VALUE_RANGE - 1);
      max_q      <= '0;
      sum_q      <= '0;
      drop_q     <= 1'b0;
      med_a_q    <= '0;
      med_b_q    <= '0;
      mode_q     <= '0;
      found_a_q  <= 1'b0;
      found_b_q  <= 1'b0;
      mirror_q   <= 1'b1;
      ovalid_q   <= 1'b0;
      res_q      <= '0;
    end else begin
      if ((state_q == StEmit) && out_free) begin
        ovalid_q <= 1'b1;
      end else if (res_ready_i) begin
        ovalid_q <= 1'b0;
      end
      hval_q     <= 1'b0;
      mval_q     <= 1'b0;
      walk_del_q <= walk_q;

      // Fold one histogram bin into median and mode.
      if (hval_q) begin
        seen_q <= seen_next;
        if (!found_a_q && (seen_next > pos_a)) begin
          found_a_q <= 1'b1;
          med_a_q   <= walk_del_q;
        end
        if (!found_b_q && (seen_next > pos_b)) begin
          found_b_q <= 1'b1;
          med_b_q   <= walk_del_q;
        end
        if (h_rd_q > best_cnt_q) begin
          best_cnt_q <= h_rd_q;
          mode_q     <= walk_del_q;
        end
      end
      if (mval_q && (s_rd_a_q != s_rd_b_q)) begin
        mirror_q <= 1'b0;
      end

      unique case (state_q)
        StClear: begin
          if (walk_q == VW'(VALUE_RANGE - 1)) begin
            walk_q  <= '0;
            state_q <= StPop;
          end else begin
            walk_q <= walk_q + 1'b1;
          end
        end
        StPop: begin
          if (head_i.valid) begin
            val_q  <= sample_clamped;
            last_q <= head_i.item.end_of_set;
            if (room) begin
              state_q <= StUpdate;
            end else begin
              drop_q <= 1'b1;
              if (head_i.item.end_of_set) begin
                state_q <= StHist;
              end
            end
          end
        end
        StUpdate: begin
          count_q <= count_q + 1'b1;
          sum_q   <= sum_q + TotalW'(val_q);
          if (val_q < min_q) min_q <= val_q;
          if (val_q > max_q) max_q <= val_q;
          state_q <= last_q ? StHist : StPop;
        end
        StHist: begin
          // Read and clear one bin per cycle.
          hval_q <= 1'b1;
          if (walk_q == VW'(VALUE_RANGE - 1)) begin
            walk_q  <= '0;
            state_q <= StHistTail;
          end else begin
            walk_q <= walk_q + 1'b1;
          end
        end
        StHistTail: begin
          idx_q   <= '0;
          state_q <= StMirror;
        end
        StMirror: begin
          if (idx_q < half) begin
            mval_q <= 1'b1;
            idx_q  <= idx_q + 1'b1;
          end else begin
            state_q <= StMirrorTail;
          end
        end
        StMirrorTail: begin
          state_q <= StEmit;
        end
        StEmit: begin
          if (out_free) begin
            res_q.minimum        <= SampleW'(min_q);
            res_q.maximum        <= SampleW'(max_q);
            res_q.total          <= sum_q;
            res_q.item_count     <= CountW'(count_q);
            res_q.median_doubled <= MedianW'({1'b0, med_a_q} + {1'b0, med_b_q});
            res_q.most_frequent  <= SampleW'(mode_q);
            res_q.is_mirror      <= mirror_q;
            res_q.overflowed     <= drop_q;
            // Return the running state to its empty-set values.
            count_q    <= '0;
            sum_q      <= '0;
            min_q      <= VW'(VALUE_RANGE - 1);
            max_q      <= '0;
            drop_q     <= 1'b0;
            seen_q     <= '0;
            best_cnt_q <= '0;
            mode_q     <= '0;
            med_a_q    <= VW'(VALUE_RANGE - 1);
            med_b_q    <= VW'(VALUE_RANGE - 1);
            found_a_q  <= 1'b0;
            found_b_q  <= 1'b0;
            mirror_q   <= 1'b1;
            state_q    <= StPop;
          end
        end
        default: begin
          state_q <= StClear;
        end
      endcase
    end
  end

  assign res_valid_o = ovalid_q;
  assign res_data_o  = res_q;

endmodule

[hw/rtl/set_statistics_engine.sv]
// Top level of the set statistics engine.
// Each stored sample beat reads its histogram bin in StPop and writes it back incremented in StUpdate.
// Closing a set walks and clears the histogram (StHist, StHistTail), compares mirror positions
// over the store's two read ports (StMirror, StMirrorTail), then registers the result in StEmit.
// Throughput: one result per set; the back end holds one set at a time.
// Reset: asynchronous, active low; then a histogram clearing pass over every bin.
module set_statistics_engine #(
  parameter int unsigned MAX_ITEMS   = sse_pkg::MaxItemsDef,
  parameter int unsigned VALUE_RANGE = sse_pkg::ValueRangeDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sse_stream_if.sink   in_i,
  sse_stream_if.source res_o
);
  import sse_pkg::*;

  queue_head_t  head;
  back_status_t status;
  sample_t      in_beat;
  result_t      res_beat;

  // Carry the input beat into the front queue.
  assign in_beat = in_i.data;

  sse_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_data_i  (in_beat),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .head_o     (head)
  );

  // Drain the queue, compute statistics, hold the result beat until taken.
  sse_back #(
    .MAX_ITEMS   (MAX_ITEMS),
    .VALUE_RANGE (VALUE_RANGE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .status_o    (status),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_data_o  (res_beat)
  );

  assign res_o.data = res_beat;

endmodule

[hw/rtl/sse_checker.sv]
// Port-level checker for the set statistics engine, bound to the top level.
module sse_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input sse_pkg::result_t res_data_i
);
  import sse_pkg::*;

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result beat withdrawn while stalled");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_data_i.minimum <= res_data_i.maximum)
    else $error("minimum above maximum");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_data_i.item_count != '0)
    else $error("result with empty set");

  a_mode_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_data_i.most_frequent >= res_data_i.minimum) &&
                    (res_data_i.most_frequent <= res_data_i.maximum))
    else $error("mode outside value span");

endmodule

bind set_statistics_engine sse_checker u_sse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);

[tb/set_statistics_engine_tb.sv]
// Self-checking testbench of the set statistics engine: random and directed sets.
`timescale 1ns / 100ps

module set_statistics_engine_tb;
  import sse_pkg::*;

  localparam int unsigned MaxItems = MaxItemsDef;
  localparam int unsigned ValueRng = ValueRangeDef;
  localparam int unsigned CycleLimit = 2000000;

  // Predicts the statistics of each set and holds them until the result beat arrives.
  class set_stats_board;
    bit [SampleW-1:0] store_q[$];
    int unsigned      hist[ValueRng];
    bit               dropped;
    result_t          pending_q[$];
    int unsigned      errors;
    int unsigned      results_seen;

    function void note_sample(sample_t s);
      result_t r;
      int unsigned n, seen, lo_pos, hi_pos, lo_v, hi_v, mode;
      bit mirror;
      bit [SampleW-1:0] mn, mx;
      int unsigned sum;
      if (store_q.size() < MaxItems) begin
        store_q.push_back(s.sample_value);
        hist[s.sample_value]++;
      end else begin
        dropped = 1'b1;
      end
      if (!s.end_of_set) return;
      n = store_q.size();
      mn = SampleW'(ValueRng - 1);
      mx = '0;
      sum = 0;
      foreach (store_q[i]) begin
        if (store_q[i] < mn) mn = store_q[i];
        if (store_q[i] > mx) mx = store_q[i];
        sum += store_q[i];
      end
      // walk the histogram for both middle positions
      lo_pos = (n - 1) / 2;
      hi_pos = n / 2;
      lo_v = ValueRng - 1;
      hi_v = ValueRng - 1;
      seen = 0;
      for (int v = 0; v < ValueRng; v++) begin
        if (seen <= lo_pos && seen + hist[v] > lo_pos) lo_v = v;
        if (seen <= hi_pos && seen + hist[v] > hi_pos) hi_v = v;
        seen += hist[v];
      end
      mode = 0;
      for (int v = 1; v < ValueRng; v++) if (hist[v] > hist[mode]) mode = v;
      mirror = 1'b1;
      for (int i = 0; i < n / 2; i++)
        if (store_q[i] != store_q[n - 1 - i]) mirror = 1'b0;
      r.minimum        = mn;
      r.maximum        = mx;
      r.total          = sum[TotalW-1:0];
      r.item_count     = n[CountW-1:0];
      r.median_doubled = MedianW'(lo_v + hi_v);
      r.most_frequent  = mode[SampleW-1:0];
      r.is_mirror      = mirror;
      r.overflowed     = dropped;
      pending_q.push_back(r);
      store_q.delete();
      foreach (hist[v]) hist[v] = 0;
      dropped = 1'b0;
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        $display("%0t: result mismatch expected %p actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  sse_stream_if #(.payload_t(sample_t)) in_if ();
  sse_stream_if #(.payload_t(result_t)) res_if ();

  set_stats_board board;
  int unsigned    cycle_cnt;
  int unsigned    src_idle_pct;
  int unsigned    snk_idle_pct;
  int unsigned    sets_sent;
  int unsigned    samples_sent;

  set_statistics_engine u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Abort on a hung handshake well beyond the slowest legal run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL set_statistics_engine");
      $finish;
    end
  end

  // Receiver: check each result beat, stall at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) board.check_result(res_if.data);
      res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Drive one sample beat; hold it until accepted, idling at random first.
  task automatic send_sample(input bit [SampleW-1:0] value, input bit last);
    sample_t s;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    s.sample_value = value;
    s.end_of_set   = last;
    in_if.valid <= 1'b1;
    in_if.data  <= s;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    board.note_sample(s);
    samples_sent++;
    if (last) sets_sent++;
  endtask

  // Send a set of the given length whose content follows the chosen shape.
  task automatic send_set(input int unsigned len, input int unsigned shape);
    bit [SampleW-1:0] vals[$];
    bit [SampleW-1:0] v;
    for (int i = 0; i < len; i++) begin
      case (shape)
        0: v = SampleW'($urandom_range(ValueRng - 1));
        1: v = SampleW'($urandom_range(3));
        2: v = SampleW'(ValueRng - 1 - $urandom_range(2));
        default: v = (i < len / 2) ? SampleW'($urandom_range(ValueRng - 1))
                                   : vals[len - 1 - i];
      endcase
      vals.push_back(v);
    end
    foreach (vals[i]) send_sample(vals[i], i == len - 1);
  endtask

  initial begin
    int unsigned wait_cnt;
    board = new();
    board.errors = 0;
    board.results_seen = 0;
    board.dropped = 1'b0;
    foreach (board.hist[v]) board.hist[v] = 0;
    cycle_cnt = 0;
    sets_sent = 0;
    samples_sent = 0;
    src_idle_pct = 19;
    snk_idle_pct = 45;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    res_if.ready = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single value, extremes, ties, mirrors and an overfull set.
    send_sample(SampleW'(0), 1'b1);
    send_sample(SampleW'(ValueRng - 1), 1'b1);
    send_sample(SampleW'(ValueRng - 1), 1'b0);
    send_sample(SampleW'(0), 1'b1);
    send_sample(SampleW'(5), 1'b0);
    send_sample(SampleW'(3), 1'b0);
    send_sample(SampleW'(5), 1'b0);
    send_sample(SampleW'(3), 1'b1);
    send_sample(SampleW'(1), 1'b0);
    send_sample(SampleW'(2), 1'b0);
    send_sample(SampleW'(1), 1'b1);
    send_sample(SampleW'(85), 1'b0);
    send_sample(SampleW'(42), 1'b0);
    send_sample(SampleW'(7), 1'b1);
    send_set(MaxItems, 2);
    send_set(MaxItems + 3, 0);

    // Random sets across the three idling phases, mostly short.
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        src_idle_pct = 45;
        snk_idle_pct = 19;
      end else if (ph == 2) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      for (int k = 0; k < 8; k++)
        send_set(($urandom_range(15) == 0) ? $urandom_range(MaxItems + 4, 2)
                                           : $urandom_range(12, 1),
                 $urandom_range(3));
    end
    in_if.valid <= 1'b0;

    wait_cnt = 0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    while (wait_cnt < 2 * ValueRng + MaxItems) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    $display("Sent %0d samples in %0d sets, checked %0d results.",
             samples_sent, sets_sent, board.results_seen);
    $display("Covered extremes, ties, mirrors, overfull sets and three idling phases.");
    if (board.errors == 0) begin
      $display("PASS set_statistics_engine");
    end else begin
      $display("FAIL set_statistics_engine");
    end
    $finish;
  end
endmodule

[sim.f]
hw/rtl/sse_pkg.sv
hw/rtl/sse_stream_if.sv
hw/rtl/sse_front.sv
hw/rtl/sse_back.sv
hw/rtl/set_statistics_engine.sv
hw/rtl/sse_checker.sv
tb/set_statistics_engine_tb.sv
